// ===== rtl/mandelbrot_tile_pixel_escape_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Mandelbrot tile pixel escape block
// Implication and next-cycle checks, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_TILE_PIXEL_ESCAPE_ASSERT_SVH
`define MANDELBROT_TILE_PIXEL_ESCAPE_ASSERT_SVH

// same-cycle implication
`define MTPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mtpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mtpe_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mtpe_pkg;

	localparam int FRAC_BITS = 32;
	localparam int ACC_W     = FRAC_BITS + 64;
	localparam int DIV_NW    = 64;
	localparam int DIV_DW    = 17;

	localparam logic [63:0] FOUR_FX    = 64'(4) << FRAC_BITS;
	localparam logic [7:0]  PAL_SCALE  = 8'd254;

	localparam logic [63:0] RST_CRE   = 64'hFFFF_FFFF_4000_0000;
	localparam logic [63:0] RST_CIM   = 64'd0;
	localparam logic [62:0] RST_SPAN  = 63'd12884901888;
	localparam logic [14:0] RST_GRID  = 15'd4096;
	localparam logic [8:0]  RST_TILE  = 9'd64;
	localparam logic [16:0] RST_LIMIT = 17'd500;

	localparam logic [14:0] GRID_MIN  = 15'd64;
	localparam logic [14:0] GRID_MAX  = 15'd16384;
	localparam logic [8:0]  TILE_MIN  = 9'd8;
	localparam logic [8:0]  TILE_MAX  = 9'd256;
	localparam logic [16:0] LIMIT_MIN = 17'd16;
	localparam logic [16:0] LIMIT_MAX = 17'd100000;

	// register indexes
	localparam logic [2:0] REG_CRE   = 3'd0;
	localparam logic [2:0] REG_CIM   = 3'd1;
	localparam logic [2:0] REG_SPAN  = 3'd2;
	localparam logic [2:0] REG_GRID  = 3'd3;
	localparam logic [2:0] REG_TILE  = 3'd4;
	localparam logic [2:0] REG_LIMIT = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_CFG  = 2'd1;
	localparam logic [1:0] ST_TILE = 2'd2;
	localparam logic [1:0] ST_PIX  = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_DIV_PS,
		OP_CHK,
		OP_DIV_TILE,
		OP_DIV_STEP,
		OP_MUL_RE,
		OP_MUL_IM,
		OP_MUL_ZR2,
		OP_MUL_ZI2,
		OP_MUL_ZRZI,
		OP_NOESC,
		OP_DIV_PAL
	} op_t;

	typedef struct packed {
		logic go;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic unit_done;
		logic err;
		logic escaped;
		logic it_end;
	} stat_t;

endpackage

// ===== rtl/mtpe_div.sv =====
// ----------------------------------------------------------------------------
// mtpe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtpe_div import mtpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_NW-1:0] quot,
	output logic [DIV_DW-1:0] rem
);

	localparam int CNT_W = $clog2(DIV_NW);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_NW-1:0] quot_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (run_q) begin
			num_q  <= {num_q[DIV_NW-2:0], 1'b0};
			quot_q <= {quot_q[DIV_NW-2:0], fits};
			rem_q  <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/mtpe_mul.sv =====
// ----------------------------------------------------------------------------
// mtpe_mul
// 64x64 multiplier from four 32x32 partial products; fixed-point or low word.
// ----------------------------------------------------------------------------
module mtpe_mul import mtpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        fx,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] prod
);

	logic             run_q;
	logic             done_q;
	logic [2:0]       cnt_q;
	logic [63:0]      a_q;
	logic [63:0]      b_q;
	logic             fx_q;
	logic [63:0]      pp_q;
	logic [1:0]       sh_q;
	logic [ACC_W-1:0] acc_q;
	logic [31:0]      pa;
	logic [31:0]      pb;
	logic [1:0]       sh;
	logic [ACC_W-1:0] pp_ext;
	logic [63:0]      corr;

	always_comb begin
		case (cnt_q)
			3'd0: begin pa = a_q[31:0];  pb = b_q[31:0];  sh = 2'd0; end
			3'd1: begin pa = a_q[31:0];  pb = b_q[63:32]; sh = 2'd1; end
			3'd2: begin pa = a_q[63:32]; pb = b_q[31:0];  sh = 2'd1; end
			default: begin pa = a_q[63:32]; pb = b_q[63:32]; sh = 2'd2; end
		endcase
	end

	always_comb begin
		case (sh_q)
			2'd0:    pp_ext = ACC_W'(pp_q);
			2'd1:    pp_ext = ACC_W'({pp_q, 32'b0});
			default: pp_ext = ACC_W'({pp_q, 64'b0});
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 3'd4) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			fx_q  <= fx;
			acc_q <= '0;
		end else if (run_q) begin
			if (cnt_q < 3'd4) begin
				pp_q <= 64'(pa) * 64'(pb);
				sh_q <= sh;
			end
			if (cnt_q != 3'd0)
				acc_q <= acc_q + pp_ext;
		end
	end

	// two's complement fix-up of the unsigned product's high word
	assign corr = (a_q[63] ? b_q : 64'd0) + (b_q[63] ? a_q : 64'd0);
	assign prod = fx_q ? (acc_q[ACC_W-1:FRAC_BITS] - (corr << (64 - FRAC_BITS)))
	                   : acc_q[63:0];
	assign done = done_q;

endmodule

// ===== rtl/mtpe_dp.sv =====
// ----------------------------------------------------------------------------
// mtpe_dp
// Datapath: config registers, checks, pixel mapping and escape iteration.
// ----------------------------------------------------------------------------
module mtpe_dp import mtpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [21:0] tile_number,
	input  logic [7:0]  pixel_column,
	input  logic [7:0]  pixel_row,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  cmd_t        cmd,
	output stat_t       st,
	output logic [7:0]  palette_index,
	output logic [1:0]  status
);

	logic [63:0] cre_cfg_q, cim_cfg_q;
	logic [62:0] span_q;
	logic [14:0] grid_q;
	logic [8:0]  tile_q;
	logic [16:0] limit_q;

	logic [21:0] tnum_q;
	logic [7:0]  col_q, row_q;
	logic [11:0] ps_q, tx_q, ty_q;
	logic        psrem_nz_q;
	logic [63:0] step_q;
	logic [63:0] cre_q, cim_q, zr_q, zi_q, zr2_q, zi2_q;
	logic [16:0] it_q;
	logic [7:0]  palette_q;
	logic [1:0]  status_q;

	logic              div_start, div_done;
	logic [DIV_NW-1:0] div_num, div_quot;
	logic [DIV_DW-1:0] div_den, div_rem;
	logic              mul_start, mul_done, mul_fx;
	logic [63:0]       mul_a, mul_b, mul_prod;

	logic [21:0] xidx, yidx;
	logic [23:0] tiles;
	logic [24:0] pal_num;
	logic [63:0] org_re, org_im, zsum;
	logic        cfg_err, tile_err, pix_err;
	logic [1:0]  code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cre_cfg_q <= RST_CRE;
			cim_cfg_q <= RST_CIM;
			span_q    <= RST_SPAN;
			grid_q    <= RST_GRID;
			tile_q    <= RST_TILE;
			limit_q   <= RST_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CRE:   cre_cfg_q <= cfg_data;
				REG_CIM:   cim_cfg_q <= cfg_data;
				REG_SPAN:  span_q    <= cfg_data[62:0];
				REG_GRID:  grid_q    <= cfg_data[14:0];
				REG_TILE:  tile_q    <= cfg_data[8:0];
				REG_LIMIT: limit_q   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign xidx    = 22'(tx_q) * 22'(tile_q) + 22'(col_q);
	assign yidx    = 22'(ty_q) * 22'(tile_q) + 22'(row_q);
	assign tiles   = 24'(ps_q) * 24'(ps_q);
	assign pal_num = 25'(it_q) * 25'(PAL_SCALE);
	assign org_re  = cre_cfg_q - {2'b0, span_q[62:1]};
	assign org_im  = cim_cfg_q - {2'b0, span_q[62:1]};
	assign zsum    = zr2_q + zi2_q;

	assign cfg_err = grid_q < GRID_MIN || grid_q > GRID_MAX || tile_q < TILE_MIN ||
	                 tile_q > TILE_MAX || psrem_nz_q || limit_q < LIMIT_MIN ||
	                 limit_q > LIMIT_MAX || span_q == '0;
	assign tile_err = {2'b0, tnum_q} >= tiles;
	assign pix_err  = {1'b0, col_q} >= tile_q || {1'b0, row_q} >= tile_q;
	assign code     = cfg_err ? ST_CFG : tile_err ? ST_TILE : pix_err ? ST_PIX : ST_OK;

	// shared divider
	assign div_start = cmd.go && (cmd.op == OP_DIV_PS || cmd.op == OP_DIV_TILE ||
	                              cmd.op == OP_DIV_STEP || cmd.op == OP_DIV_PAL);
	always_comb begin
		case (cmd.op)
			OP_DIV_PS:   begin div_num = DIV_NW'(grid_q);  div_den = DIV_DW'(tile_q);  end
			OP_DIV_TILE: begin div_num = DIV_NW'(tnum_q);  div_den = DIV_DW'(ps_q);    end
			OP_DIV_STEP: begin div_num = DIV_NW'(span_q);  div_den = DIV_DW'(grid_q);  end
			default:     begin div_num = DIV_NW'(pal_num); div_den = limit_q;          end
		endcase
	end

	mtpe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// shared multiplier
	assign mul_start = cmd.go && (cmd.op == OP_MUL_RE || cmd.op == OP_MUL_IM ||
	                              cmd.op == OP_MUL_ZR2 || cmd.op == OP_MUL_ZI2 ||
	                              cmd.op == OP_MUL_ZRZI);
	always_comb begin
		mul_fx = 1'b1;
		case (cmd.op)
			OP_MUL_RE:  begin mul_a = 64'(xidx); mul_b = step_q; mul_fx = 1'b0; end
			OP_MUL_IM:  begin mul_a = 64'(yidx); mul_b = step_q; mul_fx = 1'b0; end
			OP_MUL_ZR2: begin mul_a = zr_q; mul_b = zr_q; end
			OP_MUL_ZI2: begin mul_a = zi_q; mul_b = zi_q; end
			default:    begin mul_a = zr_q; mul_b = zi_q; end
		endcase
	end

	mtpe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.fx     (mul_fx),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			tnum_q <= tile_number;
			col_q  <= pixel_column;
			row_q  <= pixel_row;
		end
		if (div_done) begin
			case (cmd.op)
				OP_DIV_PS: begin
					ps_q       <= div_quot[11:0];
					psrem_nz_q <= div_rem != '0;
				end
				OP_DIV_TILE: begin
					ty_q <= div_quot[11:0];
					tx_q <= div_rem[11:0];
				end
				OP_DIV_STEP: step_q <= div_quot[63:0];
				OP_DIV_PAL: begin
					palette_q <= div_quot[7:0] + 8'd1;
					status_q  <= ST_OK;
				end
				default: ;
			endcase
		end
		if (mul_done) begin
			case (cmd.op)
				OP_MUL_RE: cre_q <= org_re + mul_prod;
				OP_MUL_IM: begin
					cim_q <= org_im + mul_prod;
					zr_q  <= '0;
					zi_q  <= '0;
					it_q  <= '0;
				end
				OP_MUL_ZR2: zr2_q <= mul_prod;
				OP_MUL_ZI2: zi2_q <= mul_prod;
				OP_MUL_ZRZI: begin
					zr_q <= zr2_q - zi2_q + cre_q;
					zi_q <= {mul_prod[62:0], 1'b0} + cim_q;
					it_q <= it_q + 1'b1;
				end
				default: ;
			endcase
		end
		if (cmd.go && cmd.op == OP_CHK && code != ST_OK) begin
			palette_q <= '0;
			status_q  <= code;
		end
		if (cmd.go && cmd.op == OP_NOESC) begin
			palette_q <= '0;
			status_q  <= ST_OK;
		end
	end

	assign st.unit_done = div_done | mul_done;
	assign st.err       = code != ST_OK;
	assign st.escaped   = $signed(zsum) > $signed(FOUR_FX);
	assign st.it_end    = it_q == limit_q;

	assign palette_index = palette_q;
	assign status        = status_q;

endmodule

// ===== rtl/mtpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtpe_ctrl
// Controller: sequences checks, setup divides, mapping and the escape loop.
// ----------------------------------------------------------------------------
module mtpe_ctrl import mtpe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  stat_t st,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	typedef enum logic [3:0] {
		S_IDLE, S_DIVPS, S_CHK, S_DIVT, S_DIVS, S_MRE, S_MIM,
		S_TOP, S_ZR2, S_ZI2, S_ESC, S_ZRZI, S_NOESC, S_PAL
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '{go: 1'b0, op: OP_NONE};
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			cmd_q.go <= 1'b0;
			done_q   <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) begin
					busy_q  <= 1'b1;
					state_q <= S_DIVPS;
					cmd_q   <= '{go: 1'b1, op: OP_DIV_PS};
				end
				S_DIVPS: if (st.unit_done) begin
					state_q <= S_CHK;
					cmd_q   <= '{go: 1'b1, op: OP_CHK};
				end
				S_CHK: if (st.err) begin
					done_q  <= 1'b1;
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end else begin
					state_q <= S_DIVT;
					cmd_q   <= '{go: 1'b1, op: OP_DIV_TILE};
				end
				S_DIVT: if (st.unit_done) begin
					state_q <= S_DIVS;
					cmd_q   <= '{go: 1'b1, op: OP_DIV_STEP};
				end
				S_DIVS: if (st.unit_done) begin
					state_q <= S_MRE;
					cmd_q   <= '{go: 1'b1, op: OP_MUL_RE};
				end
				S_MRE: if (st.unit_done) begin
					state_q <= S_MIM;
					cmd_q   <= '{go: 1'b1, op: OP_MUL_IM};
				end
				S_MIM: if (st.unit_done) begin
					state_q <= S_TOP;
					cmd_q   <= '{go: 1'b0, op: OP_NONE};
				end
				S_TOP: if (st.it_end) begin
					state_q <= S_NOESC;
					cmd_q   <= '{go: 1'b1, op: OP_NOESC};
				end else begin
					state_q <= S_ZR2;
					cmd_q   <= '{go: 1'b1, op: OP_MUL_ZR2};
				end
				S_ZR2: if (st.unit_done) begin
					state_q <= S_ZI2;
					cmd_q   <= '{go: 1'b1, op: OP_MUL_ZI2};
				end
				S_ZI2: if (st.unit_done) begin
					state_q <= S_ESC;
					cmd_q   <= '{go: 1'b0, op: OP_NONE};
				end
				S_ESC: if (st.escaped) begin
					state_q <= S_PAL;
					cmd_q   <= '{go: 1'b1, op: OP_DIV_PAL};
				end else begin
					state_q <= S_ZRZI;
					cmd_q   <= '{go: 1'b1, op: OP_MUL_ZRZI};
				end
				S_ZRZI: if (st.unit_done) begin
					state_q <= S_TOP;
					cmd_q   <= '{go: 1'b0, op: OP_NONE};
				end
				S_NOESC: begin
					done_q  <= 1'b1;
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				S_PAL: if (st.unit_done) begin
					done_q  <= 1'b1;
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd  = cmd_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== rtl/mandelbrot_tile_pixel_escape.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_tile_pixel_escape
// Escape-time palette byte for one pixel of a tiled Q32.32 Mandelbrot render.
// ----------------------------------------------------------------------------
//
// channel   handshake                  payload
// request   start, accepted if !busy   tile_number, pixel_column, pixel_row
// result    done, one-cycle strobe     palette_index, status
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Sequence: an item first runs one divide (tiles per side) and the config,
// tile and pixel checks, and if these pass two more divides (tile row/column,
// pixel step) and two mapping multiplies as setup. Each escape iteration
// makes three passes through the shared four-partial 64x64 multiplier; an
// escaped pixel adds one more divide for the palette.
// A failed check (config, tile or pixel) gives its result, with palette 0,
// after the first divide and the checks.
// Reset (arst_n low) loads register defaults and idles the controller.
// The receiver cannot stall: done is high for one cycle per item, and a new
// item may be taken in that same cycle.
//
module mandelbrot_tile_pixel_escape import mtpe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        start,
	output logic        busy,
	input  logic [21:0] tile_number,
	input  logic [7:0]  pixel_column,
	input  logic [7:0]  pixel_row,
	// result
	output logic        done,
	output logic [7:0]  palette_index,
	output logic [1:0]  status,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	`include "mandelbrot_tile_pixel_escape_assert.svh"

	logic  accept;
	cmd_t  cmd;
	stat_t st;

	// registers may be written any time; the contract keeps writes to idle
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	mtpe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mtpe_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.tile_number   (tile_number),
		.pixel_column  (pixel_column),
		.pixel_row     (pixel_row),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.st            (st),
		.palette_index (palette_index),
		.status        (status)
	);

	// done ends busy, is not held; accept sets busy; errors give palette 0
	`MTPE_ASSERT_NOW(a_done_not_busy, done, !busy, "result while still busy")
	`MTPE_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`MTPE_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accepted item not in progress")
	`MTPE_ASSERT_NOW(a_err_zero, done && status != ST_OK, palette_index == 8'd0,
		"error result with nonzero palette")

endmodule
